@@ rtl/smas_pkg.sv @@
// Package for the soil moisture average and scale unit.
// Shared types, register indexes and fixed constants. No dependencies.
`default_nettype none

package smas_pkg;

  localparam int MOIST_W    = 10;
  localparam int DIV_STEPS  = 10;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [MOIST_W-1:0] FULL_SCALE = 10'd1000;
  localparam logic [1:0]         GROUP_LAST = 2'd3;

  // configuration register indexes
  localparam logic CFG_DRY = 1'b0;
  localparam logic CFG_WET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc;       // add the accepted sample to the sum
    logic close;     // last sample of the group: latch average, clear sum
    logic map_load;  // multiply, classify, seed divider
    logic div_step;  // one restoring divide step
    logic out_load;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // output register full and not being taken
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/soil_moisture_average_and_scale_unit.sv @@
// Top level of the soil moisture average and scale unit.
// Joins smas_ctrl and smas_datapath; uses smas_pkg.
//
// channel   direction  payload (low bit first)
// s_axis    in         adc_sample
// m_axis    out        moisture_tenths, average_raw
// cfg       in         index 0 dry_level, index 1 wet_level
//
// The first three samples of a group are only added to the sum.
// The fourth runs average/multiply, 10 divide steps (one quotient
// bit per cycle in the restoring divider) and output load.
// rst clears the sum and counters and sets dry_level 1023, wet_level 0.
// A result waits in the output register while the next three samples are taken;
// the next group's fourth sample completes only once that register is free.
`default_nettype none

module soil_moisture_average_and_scale_unit #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // adc_sample [ADC_BITS-1:0], zero padding above
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // moisture_tenths [9:0], average_raw [ADC_BITS+9:10], zero padding above
  output logic [((ADC_BITS+10+7)/8)*8-1:0]            m_axis_tdata,
  input  wire logic                                   cfg_wr_en,
  input  wire logic                                   cfg_index,
  input  wire logic [ADC_BITS-1:0]                    cfg_data
);
  import smas_pkg::*;

  localparam int OUT_W   = MOIST_W + ADC_BITS;
  localparam int OUT_TDW = ((OUT_W + 7) / 8) * 8;

  cmd_t                cmd;
  sts_t                sts;
  logic [MOIST_W-1:0]  out_moist;
  logic [ADC_BITS-1:0] out_avg;

  smas_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  smas_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample    (s_axis_tdata[ADC_BITS-1:0]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_moist (out_moist),
    .out_avg   (out_avg)
  );

  assign m_axis_tdata = OUT_TDW'({out_avg, out_moist});

endmodule

`default_nettype wire

@@ rtl/smas_ctrl.sv @@
// Controller of the soil moisture unit: group counter, divide step counter
// and sequencing state machine. Uses smas_pkg.
`default_nettype none

module smas_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  smas_pkg::sts_t     sts,
  output smas_pkg::cmd_t     cmd
);
  import smas_pkg::*;

  state_t              state, state_next;
  logic [1:0]          count;
  logic [STEP_W-1:0]   step;
  logic                accept;

  assign accept = s_axis_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count + 2'd1;
      end
      if (state == ST_MAP) begin
        step <= '0;
      end else if (state == ST_DIV) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && count == GROUP_LAST) state_next = ST_MAP;
      end
      ST_MAP:  state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.acc       = accept;
        cmd.close     = accept && (count == GROUP_LAST);
      end
      ST_MAP:  cmd.map_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.out_load = !sts.out_busy;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/smas_datapath.sv @@
// Datapath of the soil moisture unit: sum, calibration registers, multiplier,
// restoring divider and output register. Uses smas_pkg.
`default_nettype none

module smas_datapath #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [ADC_BITS-1:0]               sample,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_index,
  input  wire logic [ADC_BITS-1:0]               cfg_data,
  input  smas_pkg::cmd_t                         cmd,
  output smas_pkg::sts_t                         sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [smas_pkg::MOIST_W-1:0]           out_moist,
  output logic [ADC_BITS-1:0]                    out_avg
);
  import smas_pkg::*;

  localparam int SUM_W  = ADC_BITS + 2;
  localparam int PROD_W = ADC_BITS + MOIST_W;

  logic [ADC_BITS-1:0] dry_level;
  logic [ADC_BITS-1:0] wet_level;
  logic [SUM_W-1:0]    sample_sum;
  logic [SUM_W-1:0]    sum_add;
  logic [ADC_BITS-1:0] avg;
  logic [ADC_BITS-1:0] dry_gap;
  logic [PROD_W-1:0]   prod;
  logic [ADC_BITS-1:0] span;
  logic [ADC_BITS-1:0] rem;
  logic [MOIST_W-1:0]  quo;
  logic [ADC_BITS:0]   trial;
  logic                is_dry;
  logic                is_wet;

  assign sum_add = sample_sum + SUM_W'(sample);
  assign dry_gap = dry_level - avg;
  assign prod    = PROD_W'(dry_gap) * PROD_W'(FULL_SCALE);
  assign trial   = {rem, quo[MOIST_W-1]};

  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_level  <= '1;
      wet_level  <= '0;
      sample_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DRY: dry_level <= cfg_data;
          CFG_WET: wet_level <= cfg_data;
        endcase
      end
      if (cmd.acc) begin
        sample_sum <= cmd.close ? '0 : sum_add;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      avg <= sum_add[SUM_W-1:2];
    end
    if (cmd.map_load) begin
      // quotient is below 1024, so the high part of the product is the
      // starting remainder and the low bits are shifted in one per step
      rem    <= prod[PROD_W-1:MOIST_W];
      quo    <= prod[MOIST_W-1:0];
      span   <= dry_level - wet_level;
      is_dry <= (avg >= dry_level);
      is_wet <= (avg <= wet_level);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, span}) begin
        rem <= ADC_BITS'(trial - {1'b0, span});
        quo <= {quo[MOIST_W-2:0], 1'b1};
      end else begin
        rem <= trial[ADC_BITS-1:0];
        quo <= {quo[MOIST_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_avg <= avg;
      if (is_dry) begin
        out_moist <= '0;
      end else if (is_wet) begin
        out_moist <= FULL_SCALE;
      end else begin
        out_moist <= quo;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/smas_checker.sv @@
// Port-level checks for the soil moisture unit, bound to the top level.
// Uses smas_pkg for the full-scale constant.
`default_nettype none

module smas_checker #(
  parameter int ADC_BITS = 10
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tready,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [((ADC_BITS+10+7)/8)*8-1:0]   m_axis_tdata
);
  import smas_pkg::*;

  // out of reset the block is idle and ready for samples
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[MOIST_W-1:0] <= FULL_SCALE))
    else $error("moisture above full scale");

endmodule

bind soil_moisture_average_and_scale_unit smas_checker #(
  .ADC_BITS (ADC_BITS)
) u_smas_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/soil_moisture_average_and_scale_unit_tb.sv @@
// Testbench for soil_moisture_average_and_scale_unit: directed groups, then random phases
// over many dry/wet settings, every result checked against an in-bench scaling predictor or a pinned row.
// Depends on rtl/smas_pkg.sv and rtl/soil_moisture_average_and_scale_unit.sv.
`timescale 1ns / 1ps

module soil_moisture_average_and_scale_unit_tb;
  import smas_pkg::*;

  localparam int ADC_W       = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 108;
  localparam int HOLD_CYCLES = 300;
  localparam int N_ROWS      = 6;

  typedef struct packed {
    logic [MOIST_W-1:0] moist;
    logic [ADC_W-1:0]   avg;
  } reading_t;

  typedef struct packed {
    logic [ADC_W-1:0]        dry;
    logic [ADC_W-1:0]        wet;
    logic [3:0][ADC_W-1:0]   smp;
    logic                    pinned;
    logic [MOIST_W-1:0]      exp_moist;
    logic [ADC_W-1:0]        exp_avg;
  } group_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [ADC_W-1:0] cfg_data;

  // predictor state
  logic [ADC_W-1:0]   dry_cfg;
  logic [ADC_W-1:0]   wet_cfg;
  logic [ADC_W+1:0]   acc_sum;
  logic [1:0]         acc_count;

  reading_t pending_readings[$];
  reading_t pinned_readings[$];
  reading_t predicted;
  reading_t wanted;
  reading_t seen;
  group_row_t group_rows[N_ROWS];

  int  fault_count;
  int  cycle_count;
  bit  steady;
  bit  hold_request;

  soil_moisture_average_and_scale_unit #(.ADC_BITS(ADC_W)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // Sum one sample into the group; returns 1 and the reading on the fourth.
  function automatic bit accumulate_sample(input logic [ADC_W-1:0] smp, output reading_t r);
    logic [ADC_W-1:0] avg;
    int span;
    int gap;
    acc_sum = acc_sum + smp;
    if (acc_count != 2'd3) begin
      acc_count = acc_count + 2'd1;
      return 1'b0;
    end
    avg = acc_sum[ADC_W+1:2];
    r.avg = avg;
    // dry test first, so an inverted calibration never divides
    if (avg >= dry_cfg) r.moist = '0;
    else if (avg <= wet_cfg) r.moist = FULL_SCALE;
    else begin
      span = int'(dry_cfg) - int'(wet_cfg);
      gap  = int'(dry_cfg) - int'(avg);
      r.moist = MOIST_W'((gap * 1000) / span);
    end
    acc_sum = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (accumulate_sample(s_axis_tdata[ADC_W-1:0], predicted)) begin
          if (pinned_readings.size() > 0) predicted = pinned_readings.pop_front();
          pending_readings.push_back(predicted);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.moist = m_axis_tdata[MOIST_W-1:0];
        seen.avg   = m_axis_tdata[MOIST_W+ADC_W-1:MOIST_W];
        if (pending_readings.size() == 0) begin
          flag_fault($sformatf("result with none pending: moist=%0d avg=%0d",
                               seen.moist, seen.avg));
        end else begin
          wanted = pending_readings.pop_front();
          if (seen.moist !== wanted.moist)
            flag_fault($sformatf("moisture_tenths exp=%0d got=%0d (avg %0d)",
                                 wanted.moist, seen.moist, wanted.avg));
          if (seen.avg !== wanted.avg)
            flag_fault($sformatf("average_raw exp=%0d got=%0d", wanted.avg, seen.avg));
        end
      end
    end
  end

  // Receiver: random stalls, a long hold when asked, none while steady.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] v);
    while (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Wait for every pending reading, let the divider settle, then write both levels.
  task automatic apply_levels(input logic [ADC_W-1:0] dry, input logic [ADC_W-1:0] wet);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DRY;
    cfg_data  <= dry;
    @(posedge clk);
    dry_cfg = dry;
    cfg_index <= CFG_WET;
    cfg_data  <= wet;
    @(posedge clk);
    wet_cfg = wet;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly samples around the calibration band so the divide path is busy.
  function automatic logic [ADC_W-1:0] draw_sample();
    int r;
    int lo;
    int hi;
    r  = $urandom_range(99);
    lo = (wet_cfg < dry_cfg) ? int'(wet_cfg) : int'(dry_cfg);
    hi = (wet_cfg < dry_cfg) ? int'(dry_cfg) : int'(wet_cfg);
    lo = (lo > 8) ? lo - 8 : 0;
    hi = (hi < 1015) ? hi + 8 : 1023;
    if (r < 60) return ADC_W'($urandom_range(hi, lo));
    else if (r < 75) return $urandom_range(1) ? 10'd1023 : 10'd0;
    else return ADC_W'($urandom_range(1023));
  endfunction

  initial begin
    int dry;
    int wet;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_DRY;
    cfg_data  = '0;
    fault_count = 0;
    cycle_count = 0;
    steady = 1'b0;
    hold_request = 1'b0;
    dry_cfg = 10'd1023;
    wet_cfg = 10'd0;
    acc_sum = '0;
    acc_count = '0;

    // all-zero group at reset levels: fully wet
    group_rows[0] = '{10'd1023, 10'd0, {10'd0, 10'd0, 10'd0, 10'd0},
                      1'b1, 10'd1000, 10'd0};
    // mid-band: (600-400)*1000/400
    group_rows[1] = '{10'd600, 10'd200, {10'd402, 10'd401, 10'd400, 10'd400},
                      1'b1, 10'd500, 10'd400};
    // one step inside the dry level, truncated quotient
    group_rows[2] = '{10'd600, 10'd200, {10'd602, 10'd599, 10'd599, 10'd599},
                      1'b0, 10'd0, 10'd0};
    // inverted calibration, below dry level: fully wet
    group_rows[3] = '{10'd200, 10'd600, {10'd100, 10'd102, 10'd101, 10'd100},
                      1'b1, 10'd1000, 10'd100};
    // dry equals wet, avg on it: dry wins; full-scale sample in the group
    group_rows[4] = '{10'd500, 10'd500, {10'd500, 10'd477, 10'd0, 10'd1023},
                      1'b1, 10'd0, 10'd500};
    // narrowest span that divides
    group_rows[5] = '{10'd2, 10'd0, {10'd1, 10'd2, 10'd0, 10'd1},
                      1'b1, 10'd500, 10'd1};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (group_rows[i]) begin
      apply_levels(group_rows[i].dry, group_rows[i].wet);
      if (group_rows[i].pinned)
        pinned_readings.push_back('{group_rows[i].exp_moist, group_rows[i].exp_avg});
      for (int k = 0; k < 4; k++) send_sample(group_rows[i].smp[k]);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dry = 1023; wet = 0; end
        1: begin dry = 700; wet = 300; end
        2: begin dry = 0; wet = 0; end
        3: begin dry = 1023; wet = 1023; end
        4: begin dry = 512; wet = 510; end
        5: begin dry = 0; wet = 1023; end
        6: begin
          dry = $urandom_range(1023, 2);
          wet = $urandom_range(dry - 1, 0);
        end
        8: begin dry = 900; wet = 5; end
        default: begin
          dry = $urandom_range(1023);
          wet = $urandom_range(1023);
        end
      endcase
      apply_levels(ADC_W'(dry), ADC_W'(wet));
      steady = (p == 6);
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(draw_sample());
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);

    fault_count += pending_readings.size();
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/smas_pkg.sv
rtl/smas_ctrl.sv
rtl/smas_datapath.sv
rtl/soil_moisture_average_and_scale_unit.sv
rtl/smas_checker.sv
test/soil_moisture_average_and_scale_unit_tb.sv
